FILE: hw/rtl/avkf_pkg.sv
// Shared types, constants and helpers of the altitude and velocity Kalman filter.
// Holds the microprogram ROM used by the top-level sequencer.
// Depends on nothing.
package avkf_pkg;

	typedef logic signed [47:0] q_t;

	localparam q_t MAX48 = 48'sh7FFF_FFFF_FFFF;
	localparam q_t MIN48 = 48'sh8000_0000_0000;

	localparam logic [31:0] TIME_STEP_RST = 32'd655;
	localparam logic [31:0] ACCEL_DEV_RST = 32'd65536;
	localparam logic [31:0] ALT_DEV_RST = 32'd65536;
	localparam logic [31:0] GRAVITY_RST = 32'd642908;

	localparam q_t Q_ONE = 48'sd65536;
	localparam q_t Q_HALF = 48'sd32768;
	localparam q_t Q_QUARTER = 48'sd16384;
	localparam q_t Q_INIT_VAR = 48'sd6553600;

	typedef enum logic [1:0] {
		CFG_TIME_STEP,
		CFG_ACCEL_DEV,
		CFG_ALT_DEV,
		CFG_GRAVITY
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FN_PREDICT,
		FN_UPDATE,
		FN_INIT,
		FN_NONE
	} func_t;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_SKZ,
		OP_END
	} op_t;

	// Codes below sixteen name entries of the register file.
	typedef enum logic [4:0] {
		S_X0, S_X1, S_P0, S_P1, S_P2, S_P3,
		S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_T8, S_T9,
		S_ZERO, S_ONE, S_HALF, S_QUART, S_INITV,
		S_DT, S_SA, S_SR, S_GRAV, S_VAL, S_VAL2
	} src_t;

	typedef struct packed {
		op_t op;
		src_t a;
		src_t b;
		src_t d;
	} instr_t;

	localparam int PC_W = 7;
	localparam int RF_DEPTH = 16;
	localparam logic [PC_W-1:0] ENT_PREDICT = 7'd0;
	localparam logic [PC_W-1:0] ENT_UPDATE = 7'd30;
	localparam logic [PC_W-1:0] ENT_RESET = 7'd64;
	localparam logic [PC_W-1:0] ENT_INIT = 7'd71;
	localparam logic [PC_W-1:0] ENT_NONE = 7'd78;
	localparam logic [PC_W-1:0] PROG_LEN = 7'd79;

	function automatic logic [47:0] mag48(input q_t a);
		return a[47] ? (~a + 48'd1) : a;
	endfunction

	function automatic q_t sat_mag(input logic [64:0] m, input logic neg);
		if (neg) begin
			if (m >= 65'h8000_0000_0000)
				return MIN48;
			return q_t'(~m[47:0] + 48'd1);
		end
		if (m > 65'h7FFF_FFFF_FFFF)
			return MAX48;
		return q_t'(m[47:0]);
	endfunction

	function automatic q_t sat_sum(input logic signed [48:0] s);
		if (s[48] != s[47])
			return s[48] ? MIN48 : MAX48;
		return q_t'(s[47:0]);
	endfunction

	function automatic instr_t prog_rom(input logic [PC_W-1:0] pc);
		instr_t i;
		i = '{OP_END, S_ZERO, S_ZERO, S_ZERO};
		case (pc)
			// Predict.
			7'd0: i = '{OP_ADD, S_VAL, S_GRAV, S_T0};
			7'd1: i = '{OP_MUL, S_DT, S_DT, S_T1};
			7'd2: i = '{OP_MUL, S_T1, S_DT, S_T2};
			7'd3: i = '{OP_MUL, S_T2, S_DT, S_T3};
			7'd4: i = '{OP_MUL, S_SA, S_SA, S_T4};
			7'd5: i = '{OP_MUL, S_T3, S_QUART, S_T3};
			7'd6: i = '{OP_MUL, S_T3, S_T4, S_T3};
			7'd7: i = '{OP_MUL, S_T2, S_HALF, S_T2};
			7'd8: i = '{OP_MUL, S_T2, S_T4, S_T2};
			7'd9: i = '{OP_MUL, S_T1, S_T4, S_T4};
			7'd10: i = '{OP_MUL, S_DT, S_X1, S_T5};
			7'd11: i = '{OP_ADD, S_X0, S_T5, S_T5};
			7'd12: i = '{OP_MUL, S_T1, S_HALF, S_T6};
			7'd13: i = '{OP_MUL, S_T6, S_T0, S_T6};
			7'd14: i = '{OP_ADD, S_T5, S_T6, S_X0};
			7'd15: i = '{OP_MUL, S_DT, S_T0, S_T7};
			7'd16: i = '{OP_ADD, S_X1, S_T7, S_X1};
			7'd17: i = '{OP_MUL, S_DT, S_P2, S_T5};
			7'd18: i = '{OP_ADD, S_P0, S_T5, S_T5};
			7'd19: i = '{OP_MUL, S_DT, S_P3, S_T6};
			7'd20: i = '{OP_ADD, S_P1, S_T6, S_T6};
			7'd21: i = '{OP_MUL, S_T6, S_DT, S_T7};
			7'd22: i = '{OP_ADD, S_T5, S_T7, S_T7};
			7'd23: i = '{OP_ADD, S_T7, S_T3, S_P0};
			7'd24: i = '{OP_ADD, S_T6, S_T2, S_P1};
			7'd25: i = '{OP_MUL, S_P3, S_DT, S_T7};
			7'd26: i = '{OP_ADD, S_P2, S_T7, S_T7};
			7'd27: i = '{OP_ADD, S_T7, S_T2, S_P2};
			7'd28: i = '{OP_ADD, S_P3, S_T4, S_P3};
			7'd29: i = '{OP_END, S_ZERO, S_ZERO, S_ZERO};
			// Update.
			7'd30: i = '{OP_MUL, S_SR, S_SR, S_T0};
			7'd31: i = '{OP_ADD, S_P0, S_T0, S_T1};
			7'd32: i = '{OP_SKZ, S_T1, S_ZERO, S_ZERO};
			7'd33: i = '{OP_DIV, S_P0, S_T1, S_T2};
			7'd34: i = '{OP_DIV, S_P2, S_T1, S_T3};
			7'd35: i = '{OP_SUB, S_VAL, S_X0, S_T4};
			7'd36: i = '{OP_MUL, S_T2, S_T4, S_T5};
			7'd37: i = '{OP_ADD, S_X0, S_T5, S_X0};
			7'd38: i = '{OP_MUL, S_T3, S_T4, S_T5};
			7'd39: i = '{OP_ADD, S_X1, S_T5, S_X1};
			7'd40: i = '{OP_SUB, S_ONE, S_T2, S_T4};
			7'd41: i = '{OP_MUL, S_T4, S_P0, S_T5};
			7'd42: i = '{OP_MUL, S_T4, S_P1, S_T6};
			7'd43: i = '{OP_MUL, S_T3, S_P0, S_T7};
			7'd44: i = '{OP_SUB, S_P2, S_T7, S_T7};
			7'd45: i = '{OP_MUL, S_T3, S_P1, S_T8};
			7'd46: i = '{OP_SUB, S_P3, S_T8, S_T8};
			7'd47: i = '{OP_MUL, S_T2, S_T0, S_T9};
			7'd48: i = '{OP_MUL, S_T3, S_T0, S_T0};
			7'd49: i = '{OP_MUL, S_T5, S_T4, S_T1};
			7'd50: i = '{OP_MUL, S_T9, S_T2, S_P0};
			7'd51: i = '{OP_ADD, S_T1, S_P0, S_P0};
			7'd52: i = '{OP_MUL, S_T5, S_T3, S_T1};
			7'd53: i = '{OP_SUB, S_T6, S_T1, S_T1};
			7'd54: i = '{OP_MUL, S_T9, S_T3, S_P1};
			7'd55: i = '{OP_ADD, S_T1, S_P1, S_P1};
			7'd56: i = '{OP_MUL, S_T7, S_T4, S_T1};
			7'd57: i = '{OP_MUL, S_T0, S_T2, S_P2};
			7'd58: i = '{OP_ADD, S_T1, S_P2, S_P2};
			7'd59: i = '{OP_MUL, S_T7, S_T3, S_T1};
			7'd60: i = '{OP_SUB, S_T8, S_T1, S_T1};
			7'd61: i = '{OP_MUL, S_T0, S_T3, S_P3};
			7'd62: i = '{OP_ADD, S_T1, S_P3, S_P3};
			7'd63: i = '{OP_END, S_ZERO, S_ZERO, S_ZERO};
			// Reset load.
			7'd64: i = '{OP_ADD, S_ZERO, S_ZERO, S_X0};
			7'd65: i = '{OP_ADD, S_ZERO, S_ZERO, S_X1};
			7'd66: i = '{OP_ADD, S_INITV, S_ZERO, S_P0};
			7'd67: i = '{OP_ADD, S_ZERO, S_ZERO, S_P1};
			7'd68: i = '{OP_ADD, S_ZERO, S_ZERO, S_P2};
			7'd69: i = '{OP_ADD, S_INITV, S_ZERO, S_P3};
			7'd70: i = '{OP_END, S_ZERO, S_ZERO, S_ZERO};
			// Initialize.
			7'd71: i = '{OP_ADD, S_VAL, S_ZERO, S_X0};
			7'd72: i = '{OP_ADD, S_VAL2, S_ZERO, S_X1};
			7'd73: i = '{OP_ADD, S_INITV, S_ZERO, S_P0};
			7'd74: i = '{OP_ADD, S_ZERO, S_ZERO, S_P1};
			7'd75: i = '{OP_ADD, S_ZERO, S_ZERO, S_P2};
			7'd76: i = '{OP_ADD, S_INITV, S_ZERO, S_P3};
			default: i = '{OP_END, S_ZERO, S_ZERO, S_ZERO};
		endcase
		return i;
	endfunction

endpackage

FILE: hw/rtl/avkf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module avkf_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/avkf_mul.sv
// Multi-cycle saturating Q32.16 multiplier built on one shared 32x32 multiplier.
// Depends on avkf_pkg.
module avkf_mul import avkf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  q_t   a,
	input  q_t   b,
	output logic done,
	output q_t   result
);

	logic [47:0] ua_q, ub_q;
	logic        neg_q;
	logic        busy_q, done_q;
	logic [1:0]  cnt_q;
	logic [63:0] lo_q;
	logic [48:0] mid_q;
	q_t          res_q;
	logic [31:0] mx, my;
	logic [63:0] prod;
	logic        hi;
	logic [48:0] comb;
	logic [64:0] m;

	always_comb begin
		case (cnt_q)
			2'd0: begin
				mx = ua_q[31:0];
				my = ub_q[31:0];
			end
			2'd1: begin
				mx = {16'd0, ua_q[47:32]};
				my = ub_q[31:0];
			end
			default: begin
				mx = ua_q[31:0];
				my = {16'd0, ub_q[47:32]};
			end
		endcase
		prod = mx * my;
		hi = (ua_q[47:32] != 16'd0) && (ub_q[47:32] != 16'd0);
		comb = {2'b00, mid_q[30:0], 16'd0} + {1'b0, lo_q[63:16]};
		if (hi || (mid_q >= 49'h0_0000_8000_0000))
			m = 65'h1_0000_0000_0000;
		else
			m = {16'd0, comb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q <= mag48(a);
			ub_q <= mag48(b);
			neg_q <= a[47] != b[47];
		end else if (busy_q) begin
			case (cnt_q)
				2'd0: lo_q <= prod;
				2'd1: mid_q <= {1'b0, prod[47:0]};
				2'd2: mid_q <= mid_q + {1'b0, prod[47:0]};
				default: res_q <= sat_mag(m, neg_q);
			endcase
		end
	end

	assign done = done_q;
	assign result = res_q;

endmodule

FILE: hw/rtl/avkf_div.sv
// Restoring radix-2 divider giving the saturated Q32.16 quotient, one bit a cycle.
// Depends on avkf_pkg.
module avkf_div import avkf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  q_t   num,
	input  q_t   den,
	output logic done,
	output q_t   result
);

	logic        busy_q, done_q;
	logic [6:0]  cnt_q;
	logic        neg_q;
	logic [47:0] ud_q, rem_q;
	logic [63:0] dvd_q;
	q_t          res_q;
	logic [49:0] diff;
	logic        ge;

	always_comb begin
		diff = {1'b0, rem_q, dvd_q[63]} - {2'b00, ud_q};
		ge = !diff[49];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd64) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[47] != den[47];
			ud_q <= mag48(den);
			dvd_q <= {mag48(num), 16'd0};
			rem_q <= 48'd0;
		end else if (busy_q) begin
			if (cnt_q == 7'd64) begin
				res_q <= sat_mag({1'b0, dvd_q}, neg_q);
			end else begin
				rem_q <= ge ? diff[47:0] : {rem_q[46:0], dvd_q[63]};
				dvd_q <= {dvd_q[62:0], ge};
			end
		end
	end

	assign done = done_q;
	assign result = res_q;

endmodule

FILE: hw/rtl/altitude_velocity_kalman_filter_top.sv
// Two-state altitude and velocity Kalman filter, signed Q32.16, top level.
// A microprogram sequencer drives one multiplier, one divider and an adder.
// Depends on avkf_pkg, avkf_ram, avkf_mul and avkf_div.
//
// An input transaction (item_valid high, item_stall low) carries func and one or
// two values: predict with acceleration, update with measured altitude, or
// initialize with altitude and velocity. Each transaction yields exactly one
// result transaction with the altitude and velocity estimates.
// Work on a transaction steps through a microprogram, one instruction at a time.
// An add or subtract is written back in the execute state, a multiply waits
// on the shared 32x32 multiplier and a divide on the bit-serial divider. An
// update ends early, skipping its divides, when the innovation variance is
// zero, and an unused func runs only the end instruction. The block returns
// to idle before the next transaction is taken, and item_stall stays high
// meanwhile.
// Results sit in an output register; a new transaction is taken while one
// waits, and a finished one holds in the sequencer until that register frees.
// Configuration writes (cfg_valid with cfg_ready) are taken in any cycle and
// must only be issued while the block is idle.
// After reset the sequencer runs the reset load, loading the zero state and the
// diagonal covariance, before it accepts a transaction.
module altitude_velocity_kalman_filter_top import avkf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  func,
	input  q_t          value,
	input  q_t          value_two,
	output logic        result_valid,
	input  logic        result_stall,
	output q_t          altitude_estimate,
	output q_t          velocity_estimate,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FETCH = 5'b00010,
		ST_EXEC  = 5'b00100,
		ST_WAIT  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [PC_W-1:0]   pc_q;
	logic              emit_q;
	logic              out_valid_q;
	q_t                est0_q, est1_q;
	q_t                alt_q, vel_q;
	q_t                val_q, val2_q;
	logic [31:0]       time_step_q, accel_dev_q, alt_dev_q, gravity_q;
	instr_t            ins;
	logic [47:0]       rd_a, rd_b;
	q_t                opa, opb;
	q_t                wdata;
	logic              ram_we;
	logic              mul_start, div_start, mul_done, div_done, unit_done;
	q_t                mul_res, div_res;
	logic              load_out;

	function automatic q_t src_val(input src_t code, input logic [47:0] rd);
		case (code)
			S_ZERO:  return '0;
			S_ONE:   return Q_ONE;
			S_HALF:  return Q_HALF;
			S_QUART: return Q_QUARTER;
			S_INITV: return Q_INIT_VAR;
			S_DT:    return q_t'({16'd0, time_step_q});
			S_SA:    return q_t'({16'd0, accel_dev_q});
			S_SR:    return q_t'({16'd0, alt_dev_q});
			S_GRAV:  return q_t'({{16{gravity_q[31]}}, gravity_q});
			S_VAL:   return val_q;
			S_VAL2:  return val2_q;
			default: return q_t'(rd);
		endcase
	endfunction

	always_comb begin
		ins = prog_rom(pc_q);
		opa = src_val(ins.a, rd_a);
		opb = src_val(ins.b, rd_b);
		mul_start = (state_q == ST_EXEC) && (ins.op == OP_MUL);
		div_start = (state_q == ST_EXEC) && (ins.op == OP_DIV);
		unit_done = (ins.op == OP_MUL) ? mul_done : div_done;
		case (ins.op)
			OP_ADD:  wdata = sat_sum({opa[47], opa} + {opb[47], opb});
			OP_SUB:  wdata = sat_sum({opa[47], opa} - {opb[47], opb});
			OP_MUL:  wdata = mul_res;
			default: wdata = div_res;
		endcase
		ram_we = ((state_q == ST_EXEC) && ((ins.op == OP_ADD) || (ins.op == OP_SUB)))
			|| ((state_q == ST_WAIT) && unit_done);
		load_out = (state_q == ST_DONE) && emit_q && (!out_valid_q || !result_stall);
	end

	avkf_ram #(.WIDTH(48), .DEPTH(RF_DEPTH)) u_rf_a (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ins.d[3:0]),
		.wdata (wdata),
		.raddr (ins.a[3:0]),
		.rdata (rd_a)
	);

	avkf_ram #(.WIDTH(48), .DEPTH(RF_DEPTH)) u_rf_b (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ins.d[3:0]),
		.wdata (wdata),
		.raddr (ins.b[3:0]),
		.rdata (rd_b)
	);

	avkf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (opa),
		.b      (opb),
		.done   (mul_done),
		.result (mul_res)
	);

	avkf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (opa),
		.den    (opb),
		.done   (div_done),
		.result (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FETCH;
			pc_q <= ENT_RESET;
			emit_q <= 1'b0;
			out_valid_q <= 1'b0;
			est0_q <= '0;
			est1_q <= '0;
			time_step_q <= TIME_STEP_RST;
			accel_dev_q <= ACCEL_DEV_RST;
			alt_dev_q <= ALT_DEV_RST;
			gravity_q <= GRAVITY_RST;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_TIME_STEP: time_step_q <= cfg_data;
					CFG_ACCEL_DEV: accel_dev_q <= cfg_data;
					CFG_ALT_DEV:   alt_dev_q <= cfg_data;
					default:       gravity_q <= cfg_data;
				endcase
			end
			if (out_valid_q && !result_stall)
				out_valid_q <= 1'b0;
			if (load_out)
				out_valid_q <= 1'b1;
			if (ram_we && (ins.d == S_X0))
				est0_q <= wdata;
			if (ram_we && (ins.d == S_X1))
				est1_q <= wdata;
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						emit_q <= 1'b1;
						state_q <= ST_FETCH;
						case (func)
							FN_PREDICT: pc_q <= ENT_PREDICT;
							FN_UPDATE:  pc_q <= ENT_UPDATE;
							FN_INIT:    pc_q <= ENT_INIT;
							default:    pc_q <= ENT_NONE;
						endcase
					end
				end
				ST_FETCH: state_q <= ST_EXEC;
				ST_EXEC: begin
					case (ins.op)
						OP_ADD, OP_SUB: begin
							pc_q <= pc_q + PC_W'(1);
							state_q <= ST_FETCH;
						end
						OP_MUL, OP_DIV: state_q <= ST_WAIT;
						OP_SKZ: begin
							if (opa == '0) begin
								state_q <= ST_DONE;
							end else begin
								pc_q <= pc_q + PC_W'(1);
								state_q <= ST_FETCH;
							end
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_WAIT: begin
					if (unit_done) begin
						pc_q <= pc_q + PC_W'(1);
						state_q <= ST_FETCH;
					end
				end
				ST_DONE: begin
					if (!emit_q || load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && item_valid) begin
			val_q <= value;
			val2_q <= value_two;
		end
		if (load_out) begin
			alt_q <= est0_q;
			vel_q <= est1_q;
		end
	end

	assign item_stall = state_q != ST_IDLE;
	assign result_valid = out_valid_q;
	assign altitude_estimate = alt_q;
	assign velocity_estimate = vel_q;
	assign cfg_ready = 1'b1;

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("Result transaction raised outside the done state.");

	a_write_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_EXEC || state_q == ST_WAIT))
		else $error("Register file written while the sequencer is not executing.");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q < PROG_LEN)
		else $error("Program counter left the microprogram.");

	a_mul_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_WAIT && ins.op == OP_MUL))
		else $error("Multiplier finished with no multiply in flight.");

endmodule

FILE: tb/tb.sv
// Self-checking testbench of the altitude and velocity Kalman filter top level.
// A scoreboard class predicts each result from its own filter state; tasks drive the block.
// Depends on avkf_pkg and altitude_velocity_kalman_filter_top.
module tb;
	import avkf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	class kalman_scoreboard;
		logic [31:0] dt, sa, sr, grav;
		q_t alt, vel;
		q_t cov[4];
		q_t exp_alt[$];
		q_t exp_vel[$];
		int errors;

		function void clear_state();
			dt = TIME_STEP_RST;
			sa = ACCEL_DEV_RST;
			sr = ALT_DEV_RST;
			grav = GRAVITY_RST;
			alt = '0;
			vel = '0;
			load_cov();
			errors = 0;
		endfunction

		function void load_cov();
			cov[0] = Q_INIT_VAR;
			cov[1] = '0;
			cov[2] = '0;
			cov[3] = Q_INIT_VAR;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [31:0] d);
			case (idx)
				CFG_TIME_STEP: dt = d;
				CFG_ACCEL_DEV: sa = d;
				CFG_ALT_DEV: sr = d;
				CFG_GRAVITY: grav = d;
			endcase
		endfunction

		function q_t clamp(logic signed [127:0] v);
			if (v > 128'sh7FFF_FFFF_FFFF)
				return MAX48;
			if (v < -128'sh8000_0000_0000)
				return MIN48;
			return q_t'(v[47:0]);
		endfunction

		function q_t qadd(q_t a, q_t b);
			logic signed [127:0] s;
			s = 128'(a) + 128'(b);
			return clamp(s);
		endfunction

		function q_t qsub(q_t a, q_t b);
			logic signed [127:0] s;
			s = 128'(a) - 128'(b);
			return clamp(s);
		endfunction

		function q_t qmul(q_t a, q_t b);
			logic [127:0] ma, mb, m;
			logic signed [127:0] r;
			ma = a[47] ? -128'(a) : 128'(a);
			mb = b[47] ? -128'(b) : 128'(b);
			m = (ma * mb) >> 16;
			r = (a[47] != b[47]) ? -$signed(m) : $signed(m);
			return clamp(r);
		endfunction

		function q_t qdiv(q_t n, q_t d);
			logic [127:0] mn, md, m;
			logic signed [127:0] r;
			mn = n[47] ? -128'(n) : 128'(n);
			md = d[47] ? -128'(d) : 128'(d);
			if (mn > 128'h8000_0000_0000)
				mn = 128'h8000_0000_0000;
			m = (mn << 16) / md;
			r = (n[47] != d[47]) ? -$signed(m) : $signed(m);
			return clamp(r);
		endfunction

		function void predict(q_t acc);
			q_t t, s, g, u, d2, d3, d4, s2, q00, q01, q11, a00, a01, a10, a11;
			t = q_t'({16'd0, dt});
			s = q_t'({16'd0, sa});
			g = q_t'($signed(grav));
			u = qadd(acc, g);
			d2 = qmul(t, t);
			d3 = qmul(d2, t);
			d4 = qmul(d3, t);
			s2 = qmul(s, s);
			q00 = qmul(qmul(d4, Q_QUARTER), s2);
			q01 = qmul(qmul(d3, Q_HALF), s2);
			q11 = qmul(d2, s2);
			alt = qadd(qadd(alt, qmul(t, vel)), qmul(qmul(d2, Q_HALF), u));
			vel = qadd(vel, qmul(t, u));
			a00 = qadd(cov[0], qmul(t, cov[2]));
			a01 = qadd(cov[1], qmul(t, cov[3]));
			a10 = cov[2];
			a11 = cov[3];
			cov[0] = qadd(qadd(a00, qmul(a01, t)), q00);
			cov[1] = qadd(a01, q01);
			cov[2] = qadd(qadd(a10, qmul(a11, t)), q01);
			cov[3] = qadd(a11, q11);
		endfunction

		function void correct(q_t z);
			q_t dev, r, s, k0, k1, y, m, b00, b01, b10, b11, kr0, kr1;
			dev = q_t'({16'd0, sr});
			r = qmul(dev, dev);
			s = qadd(cov[0], r);
			if (s == '0)
				return;
			k0 = qdiv(cov[0], s);
			k1 = qdiv(cov[2], s);
			y = qsub(z, alt);
			alt = qadd(alt, qmul(k0, y));
			vel = qadd(vel, qmul(k1, y));
			m = qsub(Q_ONE, k0);
			b00 = qmul(m, cov[0]);
			b01 = qmul(m, cov[1]);
			b10 = qsub(cov[2], qmul(k1, cov[0]));
			b11 = qsub(cov[3], qmul(k1, cov[1]));
			kr0 = qmul(k0, r);
			kr1 = qmul(k1, r);
			cov[0] = qadd(qmul(b00, m), qmul(kr0, k0));
			cov[1] = qadd(qsub(b01, qmul(b00, k1)), qmul(kr0, k1));
			cov[2] = qadd(qmul(b10, m), qmul(kr1, k0));
			cov[3] = qadd(qsub(b11, qmul(b10, k1)), qmul(kr1, k1));
		endfunction

		function void note_item(logic [1:0] fn, q_t v1, q_t v2);
			case (fn)
				FN_PREDICT: predict(v1);
				FN_UPDATE: correct(v1);
				FN_INIT: begin
					alt = v1;
					vel = v2;
					load_cov();
				end
				default: ;
			endcase
			exp_alt.push_back(alt);
			exp_vel.push_back(vel);
		endfunction

		function void check_result(q_t a, q_t v);
			q_t ea, ev;
			if (exp_alt.size() == 0) begin
				$display("%0t: unexpected result alt=%0d vel=%0d", $time, a, v);
				errors++;
				return;
			end
			ea = exp_alt.pop_front();
			ev = exp_vel.pop_front();
			if (a !== ea) begin
				$display("%0t: altitude expected %0d actual %0d", $time, ea, a);
				errors++;
			end
			if (v !== ev) begin
				$display("%0t: velocity expected %0d actual %0d", $time, ev, v);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	logic [1:0] func;
	q_t value;
	q_t value_two;
	logic result_valid;
	logic result_stall;
	q_t altitude_estimate;
	q_t velocity_estimate;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	kalman_scoreboard filter_sb;
	bit calm;
	int unsigned cycles;
	int unsigned results_seen;

	altitude_velocity_kalman_filter_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.func(func),
		.value(value),
		.value_two(value_two),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.altitude_estimate(altitude_estimate),
		.velocity_estimate(velocity_estimate),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 3000000) begin
				$display("Timeout after %0d cycles", cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int n;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					result_stall <= 1'b1;
					@(negedge clk);
				end
			end
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			filter_sb.check_result(altitude_estimate, velocity_estimate);
			results_seen++;
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [31:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		filter_sb.write_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(logic [1:0] fn, q_t v1, q_t v2);
		int n;
		@(negedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 6);
			item_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		item_valid <= 1'b1;
		func <= fn;
		value <= v1;
		value_two <= v2;
		do @(posedge clk); while (item_stall);
		filter_sb.note_item(fn, v1, v2);
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (filter_sb.exp_alt.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (400) @(posedge clk);
	endtask

	function automatic q_t rand_q(int mode);
		logic [47:0] r;
		r = 48'({$urandom, $urandom});
		case (mode)
			0: return q_t'(r);
			1: return q_t'($signed(r[27:0]));
			default: return q_t'($signed(r[35:0]));
		endcase
	endfunction

	function automatic logic [31:0] rand_reg(cfg_idx_t idx);
		case ($urandom_range(0, 3))
			0: return (idx == CFG_TIME_STEP) ? 32'd1 : 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return (idx == CFG_GRAVITY) ? $urandom : $urandom_range(1, 262144);
		endcase
	endfunction

	initial begin
		int mode;
		logic [1:0] fn;
		filter_sb = new();
		filter_sb.clear_state();
		calm = 1'b0;
		results_seen = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		func = FN_PREDICT;
		value = '0;
		value_two = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TIME_STEP;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_item(FN_PREDICT, '0, '0);
		send_item(FN_UPDATE, 48'sd6553600, '0);
		send_item(FN_INIT, MAX48, MIN48);
		send_item(FN_PREDICT, MAX48, MAX48);
		send_item(FN_UPDATE, MIN48, '0);
		send_item(FN_INIT, MIN48, MAX48);
		send_item(FN_PREDICT, MIN48, '0);
		send_item(FN_NONE, 48'sd123, 48'sd456);
		send_item(FN_UPDATE, MAX48, MIN48);
		send_item(FN_INIT, 48'sh5555_5555_5555, 48'shAAAA_AAAA_AAAA);
		send_item(FN_INIT, 48'shAAAA_AAAA_AAAA, 48'sh5555_5555_5555);
		drain();

		// Zero altimeter deviation: an update zeroes P0, then zero innovation variance.
		write_reg(CFG_ALT_DEV, 32'd0);
		write_reg(CFG_TIME_STEP, 32'd1);
		write_reg(CFG_ACCEL_DEV, 32'd0);
		write_reg(CFG_GRAVITY, 32'h8000_0000);
		send_item(FN_INIT, 48'sd1000, -48'sd20);
		send_item(FN_UPDATE, 48'sd500, '0);
		send_item(FN_UPDATE, 48'sd800, '0);
		send_item(FN_PREDICT, 48'sd700, '0);
		drain();
		write_reg(CFG_TIME_STEP, 32'hFFFF_FFFF);
		write_reg(CFG_ACCEL_DEV, 32'hFFFF_FFFF);
		write_reg(CFG_ALT_DEV, 32'hFFFF_FFFF);
		write_reg(CFG_GRAVITY, 32'h7FFF_FFFF);
		send_item(FN_PREDICT, 48'sd65536, '0);
		send_item(FN_UPDATE, -48'sd65536, '0);
		send_item(FN_PREDICT, MIN48, '0);
		drain();

		for (int phase = 0; phase < 13; phase++) begin
			if (phase == 12)
				calm = 1'b1;
			if (phase > 0) begin
				if (phase % 4 == 0) begin
					write_reg(CFG_TIME_STEP, TIME_STEP_RST);
					write_reg(CFG_ACCEL_DEV, ACCEL_DEV_RST);
					write_reg(CFG_ALT_DEV, ALT_DEV_RST);
					write_reg(CFG_GRAVITY, GRAVITY_RST);
				end else begin
					write_reg(CFG_TIME_STEP, rand_reg(CFG_TIME_STEP) | 32'd1);
					write_reg(CFG_ACCEL_DEV, rand_reg(CFG_ACCEL_DEV));
					write_reg(CFG_ALT_DEV, rand_reg(CFG_ALT_DEV));
					write_reg(CFG_GRAVITY, rand_reg(CFG_GRAVITY));
				end
			end
			send_item(FN_INIT, rand_q(1), rand_q(1));
			for (int i = 0; i < 149; i++) begin
				mode = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
				case ($urandom_range(0, 19))
					0: fn = FN_NONE;
					1, 2: fn = FN_INIT;
					3, 4, 5, 6, 7, 8, 9, 10, 11: fn = FN_PREDICT;
					default: fn = FN_UPDATE;
				endcase
				send_item(fn, rand_q(mode), rand_q(mode));
			end
			drain();
		end

		$display("Covered %0d results over 13 random phases plus directed extremes,",
			results_seen);
		$display("including register extremes, saturation and zero innovation variance.");
		if (filter_sb.errors == 0 && filter_sb.exp_alt.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

FILE: files.f
hw/rtl/avkf_pkg.sv
hw/rtl/avkf_ram.sv
hw/rtl/avkf_mul.sv
hw/rtl/avkf_div.sv
hw/rtl/altitude_velocity_kalman_filter_top.sv
tb/tb.sv
